/* rtl/mfv_pkg.sv */
// ----------------------------------------------------------------------------
// mfv_pkg
// Types, constants and helpers shared by the map file validator modules.
// ----------------------------------------------------------------------------
package mfv_pkg;

  localparam int unsigned POINT_BYTES    = 12;
  localparam int unsigned MIN_FILE_BYTES = 24;

  localparam logic [31:0] MAGIC_WORD     = 32'h5041_4D52;
  localparam logic [31:0] FORMAT_VERSION = 32'd1;
  localparam logic [63:0] FNV_START      = 64'd1469598103934665603;

  localparam logic [22:0] MAX_POINTS_RST = 23'd8000000;
  localparam logic [6:0]  MAX_SCANS_RST  = 7'd64;
  localparam logic [6:0]  SCAN_SAT       = 7'd127;

  // register indexes on the configuration port
  localparam logic CFG_MAX_POINTS = 1'b0;
  localparam logic CFG_MAX_SCANS  = 1'b1;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_VERSION = 4'd1,
    PH_VOXEL   = 4'd2,
    PH_TIME    = 4'd3,
    PH_COUNT   = 4'd4,
    PH_LENGTH  = 4'd5,
    PH_DATA    = 4'd6,
    PH_HASH    = 4'd7,
    PH_DONE    = 4'd8,
    PH_EXTRA   = 4'd9,
    PH_HALT    = 4'd10
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_TOO_SMALL  = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_HEADER_CUT = 4'd4,
    ST_SCAN_COUNT = 4'd5,
    ST_LENGTH_CUT = 4'd6,
    ST_POINTS     = 4'd7,
    ST_DATA_CUT   = 4'd8,
    ST_HASH_PLACE = 4'd9,
    ST_HASH_BAD   = 4'd10
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    status_t            status;
    logic [63:0]        voxel_bits;
    logic signed [63:0] timestamp;
    logic [6:0]         scan_total;
    logic [22:0]        point_total;
    logic [63:0]        point_hash;
  } result_t;

  // FNV-1a 64 step; prime is 2^40 + 0x1b3, so the product is shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* rtl/mfv_in_stage.sv */
// ----------------------------------------------------------------------------
// mfv_in_stage
// Input register: one byte beat per cycle unless stalled, held until taken.
// ----------------------------------------------------------------------------
module mfv_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  input  logic          take,
  output mfv_pkg::beat_t beat
);
  import mfv_pkg::*;

  logic       valid;
  logic [7:0] byte_q;
  logic       last_q;

  assign in_stall = valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

  assign beat = '{valid: valid, data_byte: byte_q, last_byte: last_q};

endmodule

/* rtl/mfv_parser.sv */
// ----------------------------------------------------------------------------
// mfv_parser
// File parser: field assembly, header checks, scan/point limits, point hash,
// final status. One byte is consumed per cycle unless a last byte is blocked.
// ----------------------------------------------------------------------------
module mfv_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_index,
  input  logic [22:0]     cfg_data,
  input  mfv_pkg::beat_t  beat,
  input  logic            out_blocked,
  output logic            take,
  output logic            res_load,
  output mfv_pkg::result_t res
);
  import mfv_pkg::*;

  logic [22:0] max_points;
  logic [6:0]  max_scans;

  phase_t      phase, phase_next;
  logic [2:0]  field_bytes, field_bytes_next;
  logic [63:0] field_shift, field_shift_next;
  logic [4:0]  total_bytes, total_bytes_next;
  logic [6:0]  scans_left, scans_left_next;
  logic [22:0] points, points_next;
  logic [26:0] data_left, data_left_next;
  logic [63:0] hash, hash_next;
  status_t     first_error, first_error_next;
  logic [63:0] voxel, voxel_next;
  logic [63:0] stamp, stamp_next;
  logic [6:0]  scan_count, scan_count_next;

  logic [63:0] field_val;
  logic [31:0] word;
  logic [2:0]  field_end;
  logic [23:0] sum;
  logic [26:0] data_dec;
  status_t     status_c;

  assign take     = beat.valid && !(beat.last_byte && out_blocked);
  assign res_load = take && beat.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_points <= MAX_POINTS_RST;
      max_scans  <= MAX_SCANS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_POINTS: max_points <= cfg_data;
        CFG_MAX_SCANS:  max_scans  <= cfg_data[6:0];
      endcase
    end
  end

  always_comb begin
    field_val = field_shift;
    field_val[{field_bytes, 3'b000} +: 8] = beat.data_byte;
    word      = field_val[31:0];
    field_end = (phase == PH_VOXEL || phase == PH_TIME || phase == PH_HASH) ? 3'd7 : 3'd3;
    sum       = {1'b0, points} + {1'b0, word[22:0]};
    data_dec  = data_left - 27'd1;

    phase_next       = phase;
    field_bytes_next = field_bytes;
    field_shift_next = field_shift;
    total_bytes_next = total_bytes;
    scans_left_next  = scans_left;
    points_next      = points;
    data_left_next   = data_left;
    hash_next        = hash;
    first_error_next = first_error;
    voxel_next       = voxel;
    stamp_next       = stamp;
    scan_count_next  = scan_count;

    if (total_bytes < 5'(MIN_FILE_BYTES)) begin
      total_bytes_next = total_bytes + 5'd1;
    end

    case (phase)
      PH_DATA: hash_next = fnv_step(hash, beat.data_byte);
      PH_DONE, PH_EXTRA: phase_next = PH_EXTRA;
      PH_HALT: ;
      default: begin
        if (field_bytes == field_end) begin
          field_bytes_next = 3'd0;
          field_shift_next = 64'd0;
          case (phase)
            PH_MAGIC: begin
              if (word != MAGIC_WORD) begin
                first_error_next = ST_MAGIC;
                phase_next       = PH_HALT;
              end else begin
                phase_next = PH_VERSION;
              end
            end
            PH_VERSION: begin
              if (word != FORMAT_VERSION) begin
                first_error_next = ST_VERSION;
                phase_next       = PH_HALT;
              end else begin
                phase_next = PH_VOXEL;
              end
            end
            PH_VOXEL: begin
              voxel_next = field_val;
              phase_next = PH_TIME;
            end
            PH_TIME: begin
              stamp_next = field_val;
              phase_next = PH_COUNT;
            end
            PH_COUNT: begin
              scan_count_next = (word > 32'(SCAN_SAT)) ? SCAN_SAT : word[6:0];
              if (word == 32'd0 || word > 32'(max_scans)) begin
                first_error_next = ST_SCAN_COUNT;
                phase_next       = PH_HALT;
              end else begin
                scans_left_next = word[6:0];
                phase_next      = PH_LENGTH;
              end
            end
            PH_LENGTH: begin
              if (word > 32'(max_points) || sum > 24'(max_points)) begin
                first_error_next = ST_POINTS;
                phase_next       = PH_HALT;
              end else begin
                points_next     = sum[22:0];
                scans_left_next = scans_left - 7'd1;
                // point bytes (x12) plus the 8-byte margin
                data_left_next  = {1'b0, word[22:0], 3'b000} + {2'b00, word[22:0], 2'b00}
                                  + 27'd8;
                if (word != 32'd0) begin
                  phase_next = PH_DATA;
                end else begin
                  phase_next = (scans_left != 7'd1) ? PH_LENGTH : PH_HASH;
                end
              end
            end
            PH_HASH: begin
              field_shift_next = field_val;
              phase_next       = PH_DONE;
            end
            default: ;
          endcase
        end else begin
          field_bytes_next = field_bytes + 3'd1;
          field_shift_next = field_val;
        end
      end
    endcase

    // margin runs down on every byte unless a fresh count was just loaded
    if (!(phase == PH_LENGTH && field_bytes == field_end && phase_next != PH_HALT)) begin
      if (data_left != 27'd0) begin
        data_left_next = data_dec;
        if (phase_next == PH_DATA && data_dec == 27'd8) begin
          phase_next = (scans_left_next != 7'd0) ? PH_LENGTH : PH_HASH;
        end
      end
    end

    if (total_bytes_next < 5'(MIN_FILE_BYTES)) begin
      status_c = ST_TOO_SMALL;
    end else if (data_left_next != 27'd0) begin
      status_c = ST_DATA_CUT;
    end else if (first_error_next != ST_OK) begin
      status_c = first_error_next;
    end else begin
      case (phase_next)
        PH_MAGIC:                     status_c = ST_MAGIC;
        PH_VERSION:                   status_c = ST_VERSION;
        PH_VOXEL, PH_TIME, PH_COUNT:  status_c = ST_HEADER_CUT;
        PH_LENGTH:                    status_c = ST_LENGTH_CUT;
        PH_DATA:                      status_c = ST_DATA_CUT;
        PH_HASH, PH_EXTRA:            status_c = ST_HASH_PLACE;
        PH_DONE: status_c = (field_shift_next == hash_next) ? ST_OK : ST_HASH_BAD;
        default:                      status_c = ST_OK;
      endcase
    end
  end

  always_comb begin
    res.status      = status_c;
    res.voxel_bits  = voxel_next;
    res.timestamp   = stamp_next;
    res.scan_total  = scan_count_next;
    res.point_total = points_next;
    res.point_hash  = hash_next;
  end

  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase       <= PH_MAGIC;
      field_bytes <= 3'd0;
      field_shift <= 64'd0;
      total_bytes <= 5'd0;
      scans_left  <= 7'd0;
      points      <= 23'd0;
      data_left   <= 27'd0;
      hash        <= FNV_START;
      first_error <= ST_OK;
      voxel       <= 64'd0;
      stamp       <= 64'd0;
      scan_count  <= 7'd0;
    end else if (take) begin
      phase       <= phase_next;
      field_bytes <= field_bytes_next;
      field_shift <= field_shift_next;
      total_bytes <= total_bytes_next;
      scans_left  <= scans_left_next;
      points      <= points_next;
      data_left   <= data_left_next;
      hash        <= hash_next;
      first_error <= first_error_next;
      voxel       <= voxel_next;
      stamp       <= stamp_next;
      scan_count  <= scan_count_next;
    end
  end

endmodule

/* rtl/mfv_out_stage.sv */
// ----------------------------------------------------------------------------
// mfv_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mfv_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_load,
  input  mfv_pkg::result_t res,
  output logic             out_blocked,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       status,
  output logic [63:0]      voxel_bits,
  output logic signed [63:0] timestamp,
  output logic [6:0]       scan_total,
  output logic [22:0]      point_total,
  output logic [63:0]      point_hash
);
  import mfv_pkg::*;

  result_t held;

  assign out_blocked = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held <= res;
    end
  end

  assign status      = held.status;
  assign voxel_bits  = held.voxel_bits;
  assign timestamp   = held.timestamp;
  assign scan_total  = held.scan_total;
  assign point_total = held.point_total;
  assign point_hash  = held.point_hash;

endmodule

/* rtl/map_file_validator_top.sv */
// ----------------------------------------------------------------------------
// map_file_validator_top
// Streaming map file validator, FNV-1a 64 content hash from a nonstandard seed.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and gives one result beat for the byte marked
// last; the parser takes that byte from the input register and loads the
// result into the result register, from which it is valid on the outputs.
// The input only stalls when a last byte reaches the parser while the previous
// result is still held by the consumer. max_points and max_scans are written
// through the configuration port; the user must write them only while no file
// is in flight, which the block does not enforce. After the last byte all
// parse state clears and the next byte starts a new file.
// ----------------------------------------------------------------------------
module map_file_validator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         status,
  output logic [63:0]        voxel_bits,
  output logic signed [63:0] timestamp,
  output logic [6:0]         scan_total,
  output logic [22:0]        point_total,
  output logic [63:0]        point_hash
);
  import mfv_pkg::*;

  beat_t   beat;
  result_t res;
  logic    take;
  logic    res_load;
  logic    out_blocked;

  mfv_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .take      (take),
    .beat      (beat)
  );

  mfv_parser u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .beat        (beat),
    .out_blocked (out_blocked),
    .take        (take),
    .res_load    (res_load),
    .res         (res)
  );

  mfv_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .res_load    (res_load),
    .res         (res),
    .out_blocked (out_blocked),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .voxel_bits  (voxel_bits),
    .timestamp   (timestamp),
    .scan_total  (scan_total),
    .point_total (point_total),
    .point_hash  (point_hash)
  );

endmodule
